>>> src/xoshiro_bounded_random_generator_defines.svh
// Assertion macros shared by the xoshiro bounded generator RTL.
`ifndef XOSHIRO_BOUNDED_RANDOM_GENERATOR_DEFINES_SVH
`define XOSHIRO_BOUNDED_RANDOM_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define XBRG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define XBRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define XBRG_ASSERT(lbl, clk, rstn, prop, msg)
`define XBRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> src/xbrg_pkg.sv
// Shared constants and unit request/response types for the bounded generator.
`default_nettype none

package xbrg_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_LOW32 = 2'd1,
    OP_RANGE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] span;
  } urem_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] rem;
  } urem_rsp_t;

endpackage

`default_nettype wire

>>> src/xbrg_wide_mul.sv
// 64x64 -> 128-bit multiplier built on one 32x32 multiplier over four partial products.
`default_nettype none

module xbrg_wide_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire xbrg_pkg::mul_req_t req_i,
  output xbrg_pkg::mul_rsp_t      rsp_o
);

  logic [63:0]  a_q, b_q;
  logic [63:0]  p_q;
  logic [1:0]   pos_q;
  logic [2:0]   cnt_q;
  logic         run_q;
  logic         done_q;
  logic [127:0] acc_q;

  logic [31:0]  a_half, b_half;
  logic [127:0] p_shifted;

  // partial product order: a0*b0, a0*b1, a1*b0, a1*b1
  assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (pos_q)
      2'd0:    p_shifted = {64'd0, p_q};
      2'd3:    p_shifted = {p_q, 64'd0};
      default: p_shifted = {32'd0, p_q, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      a_q    <= req_i.a;
      b_q    <= req_i.b;
      acc_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      if (cnt_q != 3'd4) begin
        p_q   <= 64'(a_half) * 64'(b_half);
        pos_q <= cnt_q[1:0];
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + p_shifted;
      end
      if (cnt_q == 3'd4) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
      cnt_q <= cnt_q + 3'd1;
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

>>> src/xbrg_urem.sv
// Bit-serial restoring remainder unit: computes (2^64 - span) mod span.
`default_nettype none

module xbrg_urem (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire xbrg_pkg::urem_req_t req_i,
  output xbrg_pkg::urem_rsp_t      rsp_o
);

  logic [63:0] d_q;
  logic [63:0] n_q;
  logic [63:0] rem_q;
  logic [5:0]  cnt_q;
  logic        run_q;
  logic        done_q;

  logic [64:0] trial;
  logic [64:0] diff;

  assign trial = {rem_q, n_q[63]};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      d_q    <= req_i.span;
      n_q    <= 64'd0 - req_i.span;
      rem_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      // one quotient bit per cycle; remainder stays below the divisor
      rem_q <= diff[64] ? trial[63:0] : diff[63:0];
      n_q   <= {n_q[62:0], 1'b0};
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

>>> src/xoshiro_bounded_random_generator.sv
// xoshiro256** generator with Lemire bounded draws; top level.
//
// Requests arrive on the s_axis channel: tuser carries the opcode (raw 64-bit,
// low 32 bits, bounded range, or none, which returns zero), tdata carries
// range_low and range_high. Each request yields exactly one transfer on m_axis
// carrying random_value. The seed register sits at APB address 0; a write
// rebuilds the four state words by four splitmix64 rounds with s_axis_tready
// low. Reset does the same from seed 0 before the first request is taken.
// A raw or 32-bit draw steps through S_DRAW1, S_DRAW2 and S_OUT. A bounded
// draw over less than the full 64-bit span adds a 128-bit product on the
// shared 32x32 multiplier, and, once per request, the rejection threshold on
// the bit-serial remainder unit when a product's low half falls below the
// span; each rejection adds another draw and product. One request is in
// flight at a time. The result sits in an output register, so a new request is
// accepted while the previous result waits; a stalled receiver holds the next
// result in the sequencer until the output register frees.
`default_nettype none
`include "xoshiro_bounded_random_generator_defines.svh"

module xoshiro_bounded_random_generator (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // stream request
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // [63:0] range_low, [127:64] range_high
  input  wire logic [1:0]   s_axis_tuser,  // [1:0] opcode
  // stream result
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [63:0]  m_axis_tdata,  // [63:0] random_value
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output      logic [63:0]  prdata,
  output      logic         pready
);

  typedef enum logic [3:0] {
    S_SEED_ADD,
    S_SEED_MA,
    S_SEED_WA,
    S_SEED_MB,
    S_SEED_WB,
    S_IDLE,
    S_DRAW1,
    S_DRAW2,
    S_MUL_GO,
    S_MUL_WAIT,
    S_MOD_WAIT,
    S_OUT
  } state_e;

  state_e          state_q;
  logic [63:0]     seed_q;
  logic [63:0]     sacc_q;
  logic [63:0]     z_q;
  logic [1:0]      idx_q;
  logic [63:0]     w_q [4];
  xbrg_pkg::op_e   op_q;
  logic [63:0]     low_q, span_q;
  logic [63:0]     t_q, x_q;
  logic [63:0]     hi_q, lo_q;
  logic [63:0]     floor_q;
  logic            floor_ok_q;
  logic [63:0]     res_q;
  logic            m_valid_q;
  logic [63:0]     m_data_q;

  xbrg_pkg::mul_req_t  mul_req;
  xbrg_pkg::mul_rsp_t  mul_rsp;
  xbrg_pkg::urem_req_t urem_req;
  xbrg_pkg::urem_rsp_t urem_rsp;

  logic        cfg_wr;
  logic        in_xfer;
  logic        out_load;
  logic [63:0] mul_lo, mul_hi;
  logic [63:0] w1_x5, draw_x9;
  logic [63:0] n0, n1, n2, n3;
  logic [63:0] seed_z;

  assign pready        = 1'b1;
  assign prdata        = paddr[3] ? 64'd0 : seed_q;
  assign cfg_wr        = psel & penable & pwrite & pready & ~paddr[3];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign out_load      = (state_q == S_OUT) && !cfg_wr && (!m_valid_q || m_axis_tready);

  assign mul_lo = mul_rsp.prod[63:0];
  assign mul_hi = mul_rsp.prod[127:64];

  // xoshiro256** output scrambler: rotl(w1 * 5, 7) * 9 as shift-adds
  assign w1_x5   = w_q[1] + {w_q[1][61:0], 2'b00};
  assign draw_x9 = t_q + {t_q[60:0], 3'b000};

  // state recurrence
  assign n2 = w_q[2] ^ w_q[0];
  assign n3 = w_q[3] ^ w_q[1];
  assign n1 = w_q[1] ^ n2;
  assign n0 = w_q[0] ^ n3;

  assign seed_z = mul_lo ^ {31'd0, mul_lo[63:31]};

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = x_q;
    mul_req.b     = span_q;
    case (state_q)
      S_SEED_MA: begin
        mul_req.start = 1'b1;
        mul_req.a     = z_q ^ {30'd0, z_q[63:30]};
        mul_req.b     = xbrg_pkg::MIX_MUL_A;
      end
      S_SEED_MB: begin
        mul_req.start = 1'b1;
        mul_req.a     = z_q;
        mul_req.b     = xbrg_pkg::MIX_MUL_B;
      end
      S_MUL_GO: begin
        mul_req.start = 1'b1;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  // threshold is needed only once a product falls below the span
  assign urem_req.start = (state_q == S_MUL_WAIT) && mul_rsp.done &&
                          (mul_lo < span_q) && !floor_ok_q;
  assign urem_req.span  = span_q;

  xbrg_wide_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  xbrg_urem u_urem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (urem_req),
    .rsp_o  (urem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SEED_ADD;
      seed_q     <= '0;
      sacc_q     <= '0;
      idx_q      <= '0;
      floor_ok_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_wr) begin
        seed_q  <= pwdata;
        sacc_q  <= pwdata;
        idx_q   <= '0;
        state_q <= S_SEED_ADD;
      end else begin
        case (state_q)
          S_SEED_ADD: begin
            sacc_q  <= sacc_q + xbrg_pkg::GOLDEN_STEP;
            z_q     <= sacc_q + xbrg_pkg::GOLDEN_STEP;
            state_q <= S_SEED_MA;
          end
          S_SEED_MA: begin
            state_q <= S_SEED_WA;
          end
          S_SEED_WA: begin
            if (mul_rsp.done) begin
              z_q     <= mul_lo ^ {27'd0, mul_lo[63:27]};
              state_q <= S_SEED_MB;
            end
          end
          S_SEED_MB: begin
            state_q <= S_SEED_WB;
          end
          S_SEED_WB: begin
            if (mul_rsp.done) begin
              w_q[idx_q] <= seed_z;
              idx_q      <= idx_q + 2'd1;
              state_q    <= (idx_q == 2'd3) ? S_IDLE : S_SEED_ADD;
            end
          end
          S_IDLE: begin
            if (in_xfer) begin
              op_q       <= xbrg_pkg::op_e'(s_axis_tuser);
              low_q      <= s_axis_tdata[63:0];
              span_q     <= s_axis_tdata[127:64] - s_axis_tdata[63:0] + 64'd1;
              floor_ok_q <= 1'b0;
              if (xbrg_pkg::op_e'(s_axis_tuser) == xbrg_pkg::OP_NONE) begin
                res_q   <= '0;
                state_q <= S_OUT;
              end else begin
                state_q <= S_DRAW1;
              end
            end
          end
          S_DRAW1: begin
            t_q     <= {w1_x5[56:0], w1_x5[63:57]};
            w_q[0]  <= n0;
            w_q[1]  <= n1;
            w_q[2]  <= n2 ^ {w_q[1][46:0], 17'd0};
            w_q[3]  <= {n3[18:0], n3[63:19]};
            state_q <= S_DRAW2;
          end
          S_DRAW2: begin
            x_q <= draw_x9;
            case (op_q)
              xbrg_pkg::OP_RAW: begin
                res_q   <= draw_x9;
                state_q <= S_OUT;
              end
              xbrg_pkg::OP_LOW32: begin
                res_q   <= {32'd0, draw_x9[31:0]};
                state_q <= S_OUT;
              end
              default: begin
                if (span_q == 64'd0) begin
                  // full 64-bit span
                  res_q   <= draw_x9 + low_q;
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_MUL_GO;
                end
              end
            endcase
          end
          S_MUL_GO: begin
            state_q <= S_MUL_WAIT;
          end
          S_MUL_WAIT: begin
            if (mul_rsp.done) begin
              hi_q <= mul_hi;
              lo_q <= mul_lo;
              if (mul_lo >= span_q) begin
                res_q   <= mul_hi + low_q;
                state_q <= S_OUT;
              end else if (floor_ok_q) begin
                if (mul_lo < floor_q) begin
                  state_q <= S_DRAW1;
                end else begin
                  res_q   <= mul_hi + low_q;
                  state_q <= S_OUT;
                end
              end else begin
                state_q <= S_MOD_WAIT;
              end
            end
          end
          S_MOD_WAIT: begin
            if (urem_rsp.done) begin
              floor_q    <= urem_rsp.rem;
              floor_ok_q <= 1'b1;
              if (lo_q < urem_rsp.rem) begin
                state_q <= S_DRAW1;
              end else begin
                res_q   <= hi_q + low_q;
                state_q <= S_OUT;
              end
            end
          end
          S_OUT: begin
            if (out_load) begin
              m_data_q <= res_q;
              state_q  <= S_IDLE;
            end
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

  `XBRG_ASSERT_IMP(a_mul_done_in_wait, clk_i, rst_ni, mul_rsp.done, (state_q == S_SEED_WA || state_q == S_SEED_WB || state_q == S_MUL_WAIT), "multiplier finished outside a wait state")
  `XBRG_ASSERT_IMP(a_urem_done_in_wait, clk_i, rst_ni, urem_rsp.done, (state_q == S_MOD_WAIT), "remainder unit finished outside its wait state")
  `XBRG_ASSERT_IMP(a_low32_upper_zero, clk_i, rst_ni, (state_q == S_OUT && op_q == xbrg_pkg::OP_LOW32), (res_q[63:32] == 32'd0), "32-bit draw has upper bits set")
  `XBRG_ASSERT_IMP(a_range_bound, clk_i, rst_ni, (state_q == S_OUT && op_q == xbrg_pkg::OP_RANGE && span_q != 64'd0), ((res_q - low_q) < span_q), "bounded draw outside its range")

endmodule

`default_nettype wire

>>> tb/xoshiro_bounded_random_generator_test.sv
// Self-checking testbench for the xoshiro256** bounded random generator.
`timescale 1ns / 1ps

module xoshiro_bounded_random_generator_test;

  localparam logic [3:0]  SEED_ADDR     = 4'd0;
  localparam logic [3:0]  SPARE_ADDR    = 4'd8;   // index 1, no register there
  localparam logic [63:0] ALL_ONES      = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] HALF_RANGE    = 64'h8000_0000_0000_0000;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 2_000_000;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = xbrg_pkg::OP_RAW;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [3:0]   paddr         = '0;
  logic [63:0]  pwdata        = '0;
  logic [63:0]  prdata;
  logic         pready;

  logic [63:0] gen_words [4];
  logic [63:0] pending_draws [$];
  int          mismatches   = 0;
  int          cycle_count  = 0;
  logic        calm         = 1'b0;
  int          stall_reqs   = 0;
  int          stall_served = 0;
  int          hold_left    = 0;

  xoshiro_bounded_random_generator u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---- generator model ----
  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic void load_seed(logic [63:0] seed);
    logic [63:0] acc;
    logic [63:0] z;
    acc = seed;
    for (int i = 0; i < 4; i++) begin
      acc += xbrg_pkg::GOLDEN_STEP;
      z = (acc ^ (acc >> 30)) * xbrg_pkg::MIX_MUL_A;
      z = (z ^ (z >> 27)) * xbrg_pkg::MIX_MUL_B;
      gen_words[i] = z ^ (z >> 31);
    end
  endfunction

  function automatic logic [63:0] step_xoshiro();
    logic [63:0] drawn;
    logic [63:0] shifted;
    drawn   = rotl64(gen_words[1] * 64'd5, 7) * 64'd9;
    shifted = gen_words[1] << 17;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= shifted;
    gen_words[3] = rotl64(gen_words[3], 45);
    return drawn;
  endfunction

  // Lemire: reject while the low product half falls under (2^64 - span) mod span
  function automatic logic [63:0] bounded_draw(logic [63:0] lo_b, logic [63:0] hi_b);
    logic [63:0]  span;
    logic [63:0]  floor_val;
    logic [127:0] prod;
    span = hi_b - lo_b + 64'd1;
    if (span == 64'd0) return step_xoshiro() + lo_b;
    prod = {64'd0, step_xoshiro()} * {64'd0, span};
    if (prod[63:0] < span) begin
      floor_val = (64'd0 - span) % span;
      while (prod[63:0] < floor_val) prod = {64'd0, step_xoshiro()} * {64'd0, span};
    end
    return prod[127:64] + lo_b;
  endfunction

  function automatic logic [63:0] predict_draw(logic [1:0] op, logic [63:0] lo_b,
                                               logic [63:0] hi_b);
    logic [63:0] drawn;
    drawn = 64'd0;
    case (op)
      xbrg_pkg::OP_RAW:   drawn = step_xoshiro();
      xbrg_pkg::OP_LOW32: drawn = step_xoshiro() & 64'h0000_0000_ffff_ffff;
      xbrg_pkg::OP_RANGE: drawn = bounded_draw(lo_b, hi_b);
      default:            drawn = 64'd0;   // unused opcode leaves the state alone
    endcase
    return drawn;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 20)
      $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---- monitor and checker ----
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (!rst_ni) begin
      load_seed(64'd0);
    end else begin
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR) load_seed(pwdata);
      if (s_axis_tvalid && s_axis_tready)
        pending_draws.push_back(predict_draw(s_axis_tuser, s_axis_tdata[63:0],
                                             s_axis_tdata[127:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_draws.size() == 0) begin
          report_mismatch("unexpected result transfer", m_axis_tdata, 64'd0);
        end else begin
          want = pending_draws.pop_front();
          if (m_axis_tdata !== want) report_mismatch("random_value", m_axis_tdata, want);
        end
      end
    end
  end

  // ---- receiver: random idling plus long holds on request ----
  always @(posedge clk_i) begin
    if (stall_reqs != stall_served) begin
      stall_served  <= stall_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout", $realtime);
      $display("xoshiro_bounded_random_generator_test failed");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic offer_request(xbrg_pkg::op_e op, logic [63:0] lo_b, logic [63:0] hi_b);
    if (!calm && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {hi_b, lo_b};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic random_request();
    logic [63:0]   lo_b;
    logic [63:0]   hi_b;
    logic [63:0]   tmp;
    int            pick;
    xbrg_pkg::op_e op;
    lo_b = rand64();
    hi_b = rand64();
    case ($urandom_range(0, 7))
      0: hi_b = lo_b + 64'($urandom_range(0, 15));
      1: ;
      2: hi_b = lo_b + HALF_RANGE + 64'($urandom_range(0, 255));   // heavy rejection
      3: hi_b = lo_b - 64'd1;                                      // full span
      4: if (hi_b >= lo_b) begin tmp = lo_b; lo_b = hi_b; hi_b = tmp; end
      5: hi_b = lo_b + 64'($urandom());
      6: if ($urandom_range(0, 1)) lo_b = 64'd0; else hi_b = ALL_ONES;
      default: begin
        lo_b = 64'($urandom_range(0, 100));
        hi_b = lo_b + 64'($urandom_range(0, 1000));
      end
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 2)      op = xbrg_pkg::OP_RAW;
    else if (pick < 4) op = xbrg_pkg::OP_LOW32;
    else if (pick < 9) op = xbrg_pkg::OP_RANGE;
    else               op = xbrg_pkg::OP_NONE;
    offer_request(op, lo_b, hi_b);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    // let the monitor log the last accepted request first
    @(posedge clk_i);
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [3:0] addr, logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---- tests ----
  task automatic test_directed();
    offer_request(xbrg_pkg::OP_RAW, 64'd0, 64'd0);
    offer_request(xbrg_pkg::OP_LOW32, ALL_ONES, ALL_ONES);
    offer_request(xbrg_pkg::OP_NONE, ALL_ONES, 64'd0);
    offer_request(xbrg_pkg::OP_RAW, ALL_ONES, ALL_ONES);
    offer_request(xbrg_pkg::OP_RANGE, 64'd0, 64'd0);            // span of one
    offer_request(xbrg_pkg::OP_RANGE, ALL_ONES, ALL_ONES);
    offer_request(xbrg_pkg::OP_RANGE, 64'd0, 64'd1);
    offer_request(xbrg_pkg::OP_RANGE, 64'd0, 64'd2);
    offer_request(xbrg_pkg::OP_RANGE, 64'd10, 64'd19);
    offer_request(xbrg_pkg::OP_RANGE, 64'd0, ALL_ONES);          // full span
    offer_request(xbrg_pkg::OP_RANGE, 64'd123, 64'd122);         // full span with offset
    offer_request(xbrg_pkg::OP_RANGE, ALL_ONES, ALL_ONES - 64'd1);
    offer_request(xbrg_pkg::OP_RANGE, 64'd100, 64'd10);          // reversed bounds
    offer_request(xbrg_pkg::OP_RANGE, ALL_ONES, 64'd0);          // reversed, span two
    offer_request(xbrg_pkg::OP_RANGE, 64'd0, HALF_RANGE);        // near-boundary span
    offer_request(xbrg_pkg::OP_RANGE, 64'd0, HALF_RANGE);
    offer_request(xbrg_pkg::OP_RANGE, 64'd5, HALF_RANGE + 64'd5);
    offer_request(xbrg_pkg::OP_RANGE, 64'd0, ALL_ONES - 64'd1);
    offer_request(xbrg_pkg::OP_RANGE, HALF_RANGE, ALL_ONES);
    offer_request(xbrg_pkg::OP_NONE, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    offer_request(xbrg_pkg::OP_LOW32, 64'd0, 64'd0);
    offer_request(xbrg_pkg::OP_RAW, 64'd0, 64'd0);
    settle();
  endtask

  task automatic test_seed_values();
    logic [63:0] seeds [4];
    seeds[0] = ALL_ONES;
    seeds[1] = 64'd1;
    seeds[2] = rand64();
    seeds[3] = 64'd0;
    foreach (seeds[k]) begin
      write_register(SEED_ADDR, seeds[k]);
      repeat (25) random_request();
      settle();
    end
    // no register at index 1: the state must carry on undisturbed
    write_register(SPARE_ADDR, rand64());
    repeat (25) random_request();
    settle();
  endtask

  task automatic test_random_mix();
    repeat (1550) random_request();
    settle();
  endtask

  task automatic test_no_idle();
    calm <= 1'b1;
    repeat (150) random_request();
    settle();
    calm <= 1'b0;
  endtask

  // receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_backpressure();
    calm       <= 1'b1;
    stall_reqs <= stall_reqs + 1;
    repeat (30) random_request();
    settle();
    calm <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    test_directed();
    test_seed_values();
    test_random_mix();
    test_no_idle();
    test_backpressure();
    if (pending_draws.size() != 0)
      report_mismatch("expected results never delivered", 64'd0,
                      64'(pending_draws.size()));
    if (mismatches == 0)
      $display("xoshiro_bounded_random_generator_test passed");
    else
      $display("xoshiro_bounded_random_generator_test failed");
    $finish;
  end

endmodule

>>> xoshiro_bounded_random_generator.f
+incdir+src
src/xbrg_pkg.sv
src/xbrg_wide_mul.sv
src/xbrg_urem.sv
src/xoshiro_bounded_random_generator.sv
tb/xoshiro_bounded_random_generator_test.sv
